### design/smoothed_slope_peak_detector_unit_defines.svh
// Assertion macros shared by the smoothed slope peak detector RTL.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef SMOOTHED_SLOPE_PEAK_DETECTOR_UNIT_DEFINES_SVH
`define SMOOTHED_SLOPE_PEAK_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SSPD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSPD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sspd_pkg.sv
// Shared types and constants for the smoothed slope peak detector.
// No dependencies; every design module imports this package.
package sspd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SLOPE_W     = 24;
    localparam int PEAK_W      = 23;
    localparam int GAIN_W      = 10;
    localparam int HOLD_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 23;
    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PEAK_W-1:0] THRESHOLD_RESET = 23'd3686;
    localparam logic [GAIN_W-1:0] GAIN_RESET      = 10'd100;
    localparam logic [HOLD_W-1:0] HOLD_RESET      = 8'd7;
    localparam logic [HOLD_W-1:0] STEPS_MAX       = 8'd255;

    localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = 24'sh7FFFFF;
    localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = 24'sh800000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEAK_THRESHOLD = 2'd0,
        CFG_SLOPE_GAIN     = 2'd1,
        CFG_HOLD_COUNT     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PEAK_W-1:0] peak_threshold;
        logic [GAIN_W-1:0] slope_gain;
        logic [HOLD_W-1:0] hold_count;
    } cfg_t;

    typedef struct packed {
        logic               empty;
        logic [LEVEL_W-1:0] level;
    } queue_status_t;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] smoothed_slope;
        logic                      high_found;
        logic [PEAK_W-1:0]         high_peak;
        logic                      low_found;
        logic [PEAK_W-1:0]         low_peak;
    } result_t;

    typedef struct packed {
        logic [PEAK_W-1:0] running_max;
        logic [HOLD_W-1:0] steps;
    } tracker_t;

    typedef struct packed {
        tracker_t          state;
        logic              found;
        logic [PEAK_W-1:0] peak;
    } track_out_t;

endpackage

### design/sspd_queue.sv
// Small synchronous FIFO used between the detector stages and at the result side.
// Depends on sspd_pkg for the depth and the status struct.
`include "smoothed_slope_peak_detector_unit_defines.svh"

module sspd_queue
    import sspd_pkg::*;
#(
    parameter int WIDTH = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output queue_status_t    status
);

    logic [WIDTH-1:0]   mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.empty = (level_reg == '0);
    assign status.level = level_reg;

    `SSPD_ASSERT_IMP(a_queue_no_underflow, pop, level_reg != '0, "item popped from an empty queue")
    `SSPD_ASSERT_IMP(a_queue_ptr_match, level_reg == '0, wr_ptr_reg == rd_ptr_reg, "queue pointers disagree with level")

endmodule

### design/sspd_cdiv.sv
// Two-stage signed divide by a constant, truncating toward zero.
// Uses a reciprocal multiply that is exact over the whole input range; needs sspd_pkg.
module sspd_cdiv
    import sspd_pkg::*;
#(
    parameter int IN_W    = 19,
    parameter int DIVISOR = 5
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic signed [IN_W-1:0] in_data,
    output logic                   out_valid,
    output logic signed [IN_W-1:0] out_data
);

    // With SHIFT at least the magnitude width plus log2 of the divisor, the
    // rounded-up reciprocal gives the exact floor quotient for every magnitude.
    localparam int SHIFT  = IN_W + $clog2(DIVISOR);
    localparam int PROD_W = IN_W + SHIFT;
    localparam logic [SHIFT-1:0] RECIP =
        SHIFT'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [IN_W-1:0]          mag;
    logic [PROD_W-1:0]        prod_next, prod_reg;
    logic                     neg_reg;
    logic                     v1_reg, v2_reg;
    logic [IN_W-1:0]          quot;
    logic signed [IN_W-1:0]   out_next, out_reg;

    assign mag       = in_data[IN_W-1] ? IN_W'(-in_data) : IN_W'(in_data);
    assign prod_next = PROD_W'(mag) * PROD_W'(RECIP);
    assign quot      = prod_reg[SHIFT +: IN_W];
    assign out_next  = neg_reg ? -$signed(quot) : $signed(quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        neg_reg  <= in_data[IN_W-1];
        out_reg  <= out_next;
    end

    assign out_valid = v2_reg;
    assign out_data  = out_reg;

endmodule

### design/sspd_front.sv
// Front end: takes samples, forms the moving average and the gained slope.
// Depends on sspd_pkg and sspd_cdiv; writes slopes into the middle queue.
`include "smoothed_slope_peak_detector_unit_defines.svh"

module sspd_front
    import sspd_pkg::*;
#(
    parameter int SMOOTH_TAPS = 5
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [GAIN_W-1:0]         slope_gain,
    input  queue_status_t             q_status,
    output logic                      slope_push,
    output logic signed [SLOPE_W-1:0] slope_data
);

    localparam int WIN_D  = SMOOTH_TAPS - 1;
    localparam int SUM_W  = SAMPLE_W + $clog2(SMOOTH_TAPS);
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;

    logic signed [SAMPLE_W-1:0] win_reg [WIN_D];
    logic signed [SUM_W-1:0]    sum_next, sum_reg;
    logic                       sum_vld_reg;
    logic                       accept;
    logic [LEVEL_W-1:0]         flight_reg, flight_next;
    logic [LEVEL_W:0]           occupancy;
    logic                       avg_vld;
    logic signed [SUM_W-1:0]    avg_full;
    logic signed [SAMPLE_W-1:0] avg;
    logic signed [SAMPLE_W-1:0] prev_avg_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic                       diff_vld_reg;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [PROD_W-1:0]   prod;

    // Items in flight plus stored slopes never exceed the queue depth, so the
    // pipeline never has to stop once an item is in.
    assign occupancy = {1'b0, q_status.level} + {1'b0, flight_reg};
    assign full      = (occupancy >= (LEVEL_W + 1)'(QUEUE_DEPTH));
    assign accept    = push && !full;

    always_comb
    begin
        sum_next = SUM_W'(sample);
        for (int i = 0; i < WIN_D; i++)
        begin
            sum_next = sum_next + SUM_W'(win_reg[i]);
        end
    end

    always_comb
    begin
        flight_next = flight_reg;
        if (accept && !slope_push)
        begin
            flight_next = flight_reg + 1'b1;
        end
        else if (!accept && slope_push)
        begin
            flight_next = flight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_D; i++)
            begin
                win_reg[i] <= '0;
            end
            prev_avg_reg <= '0;
            sum_vld_reg  <= 1'b0;
            diff_vld_reg <= 1'b0;
            flight_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                win_reg[0] <= sample;
                for (int i = 1; i < WIN_D; i++)
                begin
                    win_reg[i] <= win_reg[i-1];
                end
            end
            if (avg_vld)
            begin
                prev_avg_reg <= avg;
            end
            sum_vld_reg  <= accept;
            diff_vld_reg <= avg_vld;
            flight_reg   <= flight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg <= sum_next;
        end
        if (avg_vld)
        begin
            diff_reg <= DIFF_W'(avg) - DIFF_W'(prev_avg_reg);
        end
    end

    sspd_cdiv #(
        .IN_W    (SUM_W),
        .DIVISOR (SMOOTH_TAPS)
    ) u_avg_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_vld_reg),
        .in_data   (sum_reg),
        .out_valid (avg_vld),
        .out_data  (avg_full)
    );

    assign avg = avg_full[SAMPLE_W-1:0];

    assign gain_s = $signed({1'b0, slope_gain});
    assign prod   = diff_reg * gain_s;

    always_comb
    begin
        if (prod > PROD_W'(SLOPE_MAX))
        begin
            slope_data = SLOPE_MAX;
        end
        else if (prod < PROD_W'(SLOPE_MIN))
        begin
            slope_data = SLOPE_MIN;
        end
        else
        begin
            slope_data = prod[SLOPE_W-1:0];
        end
    end

    assign slope_push = diff_vld_reg;

    `SSPD_ASSERT_IMP(a_front_no_overflow, slope_push, q_status.level != LEVEL_W'(QUEUE_DEPTH), "slope written into a full queue")

endmodule

### design/sspd_back.sv
// Back end: smooths the slopes and runs the rising and falling peak trackers.
// Depends on sspd_pkg and sspd_cdiv; reads the middle queue, writes the result queue.
`include "smoothed_slope_peak_detector_unit_defines.svh"

module sspd_back
    import sspd_pkg::*;
#(
    parameter int SLOPE_TAPS = 3
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  queue_status_t             slope_status,
    input  logic signed [SLOPE_W-1:0] slope_data,
    output logic                      slope_pop,
    input  cfg_t                      cfg,
    input  queue_status_t             result_status,
    output logic                      result_push,
    output result_t                   result_data
);

    localparam int WIN_D = SLOPE_TAPS - 1;
    localparam int SUM_W = SLOPE_W + $clog2(SLOPE_TAPS);

    logic signed [SLOPE_W-1:0] win_reg [WIN_D];
    logic signed [SUM_W-1:0]   sum_next, sum_reg;
    logic                      sum_vld_reg;
    logic                      take;
    logic [LEVEL_W-1:0]        flight_reg, flight_next;
    logic [LEVEL_W:0]          occupancy;
    logic                      smooth_vld;
    logic signed [SUM_W-1:0]   smooth_full;
    logic signed [SLOPE_W-1:0] smooth;
    logic signed [SLOPE_W-1:0] neg;
    tracker_t                  high_trk_reg, low_trk_reg;
    track_out_t                high_out, low_out;

    // One tracker step. Only a non-negative value can beat the running
    // maximum, which itself never goes negative.
    function automatic track_out_t track_step(
        input tracker_t                  cur,
        input logic signed [SLOPE_W-1:0] v,
        input logic [PEAK_W-1:0]         thr,
        input logic [HOLD_W-1:0]         hold
    );
        track_out_t res;
        logic       cand;
        cand = !v[SLOPE_W-1] && (v[PEAK_W-1:0] > cur.running_max) && (v[PEAK_W-1:0] > thr);
        res.state = cur;
        if (cand)
        begin
            res.state.running_max = v[PEAK_W-1:0];
            res.state.steps       = HOLD_W'(1);
        end
        else if (cur.steps != STEPS_MAX)
        begin
            res.state.steps = cur.steps + 1'b1;
        end
        res.found = (res.state.steps == hold);
        res.peak  = '0;
        if (res.found)
        begin
            res.peak              = res.state.running_max;
            res.state.running_max = '0;
        end
        return res;
    endfunction

    assign occupancy = {1'b0, result_status.level} + {1'b0, flight_reg};
    assign take      = !slope_status.empty && (occupancy < (LEVEL_W + 1)'(QUEUE_DEPTH));
    assign slope_pop = take;

    always_comb
    begin
        sum_next = SUM_W'(slope_data);
        for (int i = 0; i < WIN_D; i++)
        begin
            sum_next = sum_next + SUM_W'(win_reg[i]);
        end
    end

    always_comb
    begin
        flight_next = flight_reg;
        if (take && !result_push)
        begin
            flight_next = flight_reg + 1'b1;
        end
        else if (!take && result_push)
        begin
            flight_next = flight_reg - 1'b1;
        end
    end

    sspd_cdiv #(
        .IN_W    (SUM_W),
        .DIVISOR (SLOPE_TAPS)
    ) u_smooth_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_vld_reg),
        .in_data   (sum_reg),
        .out_valid (smooth_vld),
        .out_data  (smooth_full)
    );

    assign smooth = smooth_full[SLOPE_W-1:0];

    // The most negative slope has no positive twin and clips to the maximum.
    assign neg = (smooth == SLOPE_MIN) ? SLOPE_MAX : -smooth;

    assign high_out = track_step(high_trk_reg, smooth, cfg.peak_threshold, cfg.hold_count);
    assign low_out  = track_step(low_trk_reg, neg, cfg.peak_threshold, cfg.hold_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_D; i++)
            begin
                win_reg[i] <= '0;
            end
            sum_vld_reg  <= 1'b0;
            flight_reg   <= '0;
            high_trk_reg <= '0;
            low_trk_reg  <= '0;
        end
        else
        begin
            if (take)
            begin
                win_reg[0] <= slope_data;
                for (int i = 1; i < WIN_D; i++)
                begin
                    win_reg[i] <= win_reg[i-1];
                end
            end
            if (smooth_vld)
            begin
                high_trk_reg <= high_out.state;
                low_trk_reg  <= low_out.state;
            end
            sum_vld_reg <= take;
            flight_reg  <= flight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sum_reg <= sum_next;
        end
    end

    assign result_push = smooth_vld;

    always_comb
    begin
        result_data.smoothed_slope = smooth;
        result_data.high_found     = high_out.found;
        result_data.high_peak      = high_out.peak;
        result_data.low_found      = low_out.found;
        result_data.low_peak       = low_out.peak;
    end

    `SSPD_ASSERT_IMP(a_back_no_overflow, result_push, result_status.level != LEVEL_W'(QUEUE_DEPTH), "result written into a full queue")
    `SSPD_ASSERT_NXT(a_back_steps_live, result_push, (high_trk_reg.steps != '0) && (low_trk_reg.steps != '0), "tracker counter is zero after a step")

endmodule

### design/smoothed_slope_peak_detector_unit.sv
// Smoothed slope peak detector, top level: one sample in, one result item out
// per sample. The block sustains one item per clock while results are popped;
// a result is ready once its sample has passed the front end's averaging and
// slope registers, the middle queue, and the back end's smoothing registers with
// peak tracking into the result queue. Both halves run without stalls once an
// item is in; an 8-entry slope queue and an 8-entry result queue absorb hold-off
// at the result side, and full rises only when those queues, together with the
// items still in flight, are used up. No clearing pass is needed after reset.
// Configuration registers may be written on any cycle (cfg_ready is always
// high), but the front and back ends read them at different stages, so write
// them only while no item is in flight.
// Depends on sspd_pkg, sspd_front, sspd_queue, sspd_back and sspd_cdiv.
module smoothed_slope_peak_detector_unit
    import sspd_pkg::*;
#(
    parameter int SMOOTH_TAPS = 5,
    parameter int SLOPE_TAPS  = 3
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SLOPE_W-1:0]  smoothed_slope,
    output logic                       high_found,
    output logic [PEAK_W-1:0]          high_peak,
    output logic                       low_found,
    output logic [PEAK_W-1:0]          low_peak,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int RESULT_W = $bits(result_t);

    cfg_t                      cfg_reg, cfg_next;
    queue_status_t             slope_status, result_status;
    logic                      slope_push, slope_pop;
    logic signed [SLOPE_W-1:0] slope_in;
    logic [SLOPE_W-1:0]        slope_head;
    logic                      result_push, result_pop;
    result_t                   result_in, result_head;
    logic [RESULT_W-1:0]       result_raw;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PEAK_THRESHOLD: cfg_next.peak_threshold = cfg_data[PEAK_W-1:0];
                CFG_SLOPE_GAIN:     cfg_next.slope_gain     = cfg_data[GAIN_W-1:0];
                CFG_HOLD_COUNT:     cfg_next.hold_count     = cfg_data[HOLD_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.peak_threshold <= THRESHOLD_RESET;
            cfg_reg.slope_gain     <= GAIN_RESET;
            cfg_reg.hold_count     <= HOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sspd_front #(
        .SMOOTH_TAPS (SMOOTH_TAPS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .sample     (sample),
        .slope_gain (cfg_reg.slope_gain),
        .q_status   (slope_status),
        .slope_push (slope_push),
        .slope_data (slope_in)
    );

    sspd_queue #(
        .WIDTH (SLOPE_W)
    ) u_slope_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (slope_push),
        .push_data (slope_in),
        .pop       (slope_pop),
        .pop_data  (slope_head),
        .status    (slope_status)
    );

    sspd_back #(
        .SLOPE_TAPS (SLOPE_TAPS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .slope_status  (slope_status),
        .slope_data    ($signed(slope_head)),
        .slope_pop     (slope_pop),
        .cfg           (cfg_reg),
        .result_status (result_status),
        .result_push   (result_push),
        .result_data   (result_in)
    );

    assign result_pop = pop && !result_status.empty;

    sspd_queue #(
        .WIDTH (RESULT_W)
    ) u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_push),
        .push_data (result_in),
        .pop       (result_pop),
        .pop_data  (result_raw),
        .status    (result_status)
    );

    assign result_head    = result_t'(result_raw);
    assign empty          = result_status.empty;
    assign smoothed_slope = result_head.smoothed_slope;
    assign high_found     = result_head.high_found;
    assign high_peak      = result_head.high_peak;
    assign low_found      = result_head.low_found;
    assign low_peak       = result_head.low_peak;

endmodule
